>>> src/pdc_pkg.sv
// Shared types and constants for the Playfair digram cipher block.
package pdc_pkg;

  localparam int unsigned MAX_CELLS = 30;

  localparam logic [7:0] HARD_SIGN    = 8'hDA;
  localparam logic [7:0] SOFT_SIGN    = 8'hDC;
  localparam logic [7:0] FILLER_RESET = 8'hD5;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_0   = 3'd0,
    REG_GRID_8   = 3'd1,
    REG_GRID_16  = 3'd2,
    REG_GRID_24  = 3'd3,
    REG_DECRYPT  = 3'd4,
    REG_FILLER   = 3'd5
  } pdc_reg_e;

  typedef struct packed {
    logic [7:0] letter;
    logic       end_of_message;
  } pdc_in_t;

  typedef struct packed {
    logic [7:0] out_letter;
    logic       last;
  } pdc_out_t;

  // Up to two letter pairs to be coded for one input item.
  typedef struct packed {
    logic       two_pairs;
    logic [7:0] a1;
    logic [7:0] b1;
    logic [7:0] a2;
    logic [7:0] b2;
    logic       eom;
  } pdc_job_t;

endpackage

>>> src/playfair_digram_cipher.sv
// Top level of the Playfair digram cipher: configuration registers and the two stages.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   in      | input     | in_valid_i/in_stall_o | pdc_in_t: letter, end of message
//   out     | output    | out_valid_o/out_stall_i | pdc_out_t: letter, last
//   cfg     | input     | cfg_valid_i/cfg_ready_o | register index, 64-bit data
//
// An item is registered in the pairing stage's job register and, after the grid lookup, in
// the result buffer, where its first letter is offered; a job waits in the job register while
// the buffer still drains. Results leave one letter per cycle unless the output stalls, and an
// item yields zero, two or four letters. The single result buffer port sets the sustained rate.
// Reset clears the pending letter and all valid flags and restores the configuration.
// An output stall holds the current letter; the input stalls only while a coded job waits
// behind a result buffer that is still draining.
module playfair_digram_cipher import pdc_pkg::*; #(
  parameter int unsigned GRID_ROWS = 5,
  parameter int unsigned GRID_COLS = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  pdc_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output pdc_out_t              out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned NCELLS = GRID_ROWS * GRID_COLS;

  logic [63:0]                  grid0_q, grid8_q, grid16_q;
  logic [47:0]                  grid24_q;
  logic                         decrypt_q;
  logic [7:0]                   filler_q;
  logic [MAX_CELLS-1:0][7:0]    grid_all;
  logic [NCELLS-1:0][7:0]       grid;
  logic                         job_valid;
  logic                         job_take;
  pdc_job_t                     job;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid0_q   <= '0;
      grid8_q   <= '0;
      grid16_q  <= '0;
      grid24_q  <= '0;
      decrypt_q <= 1'b0;
      filler_q  <= FILLER_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_GRID_0:  grid0_q   <= cfg_data_i;
        REG_GRID_8:  grid8_q   <= cfg_data_i;
        REG_GRID_16: grid16_q  <= cfg_data_i;
        REG_GRID_24: grid24_q  <= cfg_data_i[47:0];
        REG_DECRYPT: decrypt_q <= cfg_data_i[0];
        REG_FILLER:  filler_q  <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  assign grid_all = {grid24_q, grid16_q, grid8_q, grid0_q};
  assign grid     = grid_all[NCELLS-1:0];

  pdc_pairer u_pairer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .decrypt_i   (decrypt_q),
    .filler_i    (filler_q),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_take_i  (job_take)
  );

  pdc_coder #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS)
  ) u_coder (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grid_i      (grid),
    .decrypt_i   (decrypt_q),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_take_o  (job_take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> src/pdc_pairer.sv
// Input stage: letter softening, pairing with the pending letter and the job register.
module pdc_pairer import pdc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  pdc_in_t  in_data_i,
  input  logic     decrypt_i,
  input  logic [7:0] filler_i,
  output logic     job_valid_o,
  output pdc_job_t job_o,
  input  logic     job_take_i
);

  logic       pend_valid_q, pend_valid_d;
  logic [7:0] pend_letter_q, pend_letter_d;
  logic       job_valid_q, job_valid_d;
  pdc_job_t   job_q, job_d;
  logic       accept;
  logic       has_job;
  logic [7:0] ch;

  assign in_stall_o = job_valid_q && !job_take_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign ch         = (in_data_i.letter == HARD_SIGN) ? SOFT_SIGN : in_data_i.letter;

  always_comb begin
    pend_valid_d    = pend_valid_q;
    pend_letter_d   = pend_letter_q;
    has_job         = 1'b0;
    job_d.two_pairs = 1'b0;
    job_d.a1        = pend_letter_q;
    job_d.b1        = ch;
    job_d.a2        = ch;
    job_d.b2        = filler_i;
    job_d.eom       = in_data_i.end_of_message;
    if (!pend_valid_q) begin
      if (in_data_i.end_of_message) begin
        has_job       = 1'b1;
        job_d.a1      = ch;
        job_d.b1      = filler_i;
        pend_letter_d = '0;
      end else begin
        pend_valid_d  = 1'b1;
        pend_letter_d = ch;
      end
    end else if (!decrypt_i && pend_letter_q == ch && ch != filler_i) begin
      has_job  = 1'b1;
      job_d.b1 = filler_i;
      if (in_data_i.end_of_message) begin
        job_d.two_pairs = 1'b1;
        pend_valid_d    = 1'b0;
        pend_letter_d   = '0;
      end else begin
        pend_letter_d = ch;
      end
    end else begin
      has_job       = 1'b1;
      pend_valid_d  = 1'b0;
      pend_letter_d = '0;
    end
  end

  always_comb begin
    job_valid_d = job_valid_q;
    if (job_take_i) begin
      job_valid_d = 1'b0;
    end
    if (accept && has_job) begin
      job_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q  <= 1'b0;
      pend_letter_q <= '0;
      job_valid_q   <= 1'b0;
    end else begin
      job_valid_q <= job_valid_d;
      if (accept) begin
        pend_valid_q  <= pend_valid_d;
        pend_letter_q <= pend_letter_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && has_job) begin
      job_q <= job_d;
    end
  end

  assign job_valid_o = job_valid_q;
  assign job_o       = job_q;

endmodule

>>> src/pdc_coder.sv
// Grid lookup and pair coding into a four-letter result buffer, drained one letter a cycle unless stalled.
module pdc_coder import pdc_pkg::*; #(
  parameter int unsigned GRID_ROWS = 5,
  parameter int unsigned GRID_COLS = 6
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic [GRID_ROWS*GRID_COLS-1:0][7:0] grid_i,
  input  logic     decrypt_i,
  input  logic     job_valid_i,
  input  pdc_job_t job_i,
  output logic     job_take_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output pdc_out_t out_data_o
);

  localparam int unsigned NCELLS = GRID_ROWS * GRID_COLS;
  localparam int unsigned RW     = $clog2(GRID_ROWS);
  localparam int unsigned CW     = $clog2(GRID_COLS);
  localparam int unsigned KW     = $clog2(NCELLS);

  function automatic logic [KW-1:0] cell_idx(logic [RW-1:0] r, logic [CW-1:0] c);
    return KW'(r) * KW'(GRID_COLS) + KW'(c);
  endfunction

  function automatic logic [RW+CW-1:0] locate(
    logic [NCELLS-1:0][7:0] grid, logic [7:0] ch
  );
    logic [RW-1:0] hr;
    logic [CW-1:0] hc;
    hr = '0;
    hc = '0;
    for (int r = GRID_ROWS - 1; r >= 0; r--) begin
      for (int c = GRID_COLS - 1; c >= 0; c--) begin
        if (grid[cell_idx(RW'(r), CW'(c))] == ch) begin
          hr = RW'(r);
          hc = CW'(c);
        end
      end
    end
    return {hr, hc};
  endfunction

  function automatic logic [CW-1:0] step_col(logic [CW-1:0] c, logic back);
    if (back) begin
      return (c == '0) ? CW'(GRID_COLS - 1) : c - CW'(1);
    end
    return (c == CW'(GRID_COLS - 1)) ? '0 : c + CW'(1);
  endfunction

  function automatic logic [RW-1:0] step_row(logic [RW-1:0] r, logic back);
    if (back) begin
      return (r == '0) ? RW'(GRID_ROWS - 1) : r - RW'(1);
    end
    return (r == RW'(GRID_ROWS - 1)) ? '0 : r + RW'(1);
  endfunction

  function automatic logic [15:0] code_pair(
    logic [NCELLS-1:0][7:0] grid, logic [7:0] a, logic [7:0] b, logic back
  );
    logic [RW-1:0] r1, r2;
    logic [CW-1:0] c1, c2;
    logic [7:0]    x, y;
    {r1, c1} = locate(grid, a);
    {r2, c2} = locate(grid, b);
    if (r1 == r2) begin
      x = grid[cell_idx(r1, step_col(c1, back))];
      y = grid[cell_idx(r2, step_col(c2, back))];
    end else if (c1 == c2) begin
      x = grid[cell_idx(step_row(r1, back), c1)];
      y = grid[cell_idx(step_row(r2, back), c2)];
    end else begin
      x = grid[cell_idx(r1, c2)];
      y = grid[cell_idx(r2, c1)];
    end
    return {x, y};
  endfunction

  logic             res_valid_q;
  logic [1:0]       res_idx_q;
  logic             res_four_q;
  logic             res_eom_q;
  logic [3:0][7:0]  res_q;
  logic [1:0]       last_idx;
  logic             take;
  logic             final_take;
  logic             load;
  logic [15:0]      pair1, pair2;

  assign last_idx   = res_four_q ? 2'd3 : 2'd1;
  assign take       = res_valid_q && !out_stall_i;
  assign final_take = take && (res_idx_q == last_idx);
  assign job_take_o = job_valid_i && (!res_valid_q || final_take);
  assign load       = job_take_o;

  always_comb begin
    pair1 = code_pair(grid_i, job_i.a1, job_i.b1, decrypt_i);
    pair2 = code_pair(grid_i, job_i.a2, job_i.b2, decrypt_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      res_idx_q   <= '0;
    end else begin
      if (load) begin
        res_valid_q <= 1'b1;
        res_idx_q   <= '0;
      end else if (final_take) begin
        res_valid_q <= 1'b0;
        res_idx_q   <= '0;
      end else if (take) begin
        res_idx_q <= res_idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q      <= {pair2[7:0], pair2[15:8], pair1[7:0], pair1[15:8]};
      res_four_q <= job_i.two_pairs;
      res_eom_q  <= job_i.eom;
    end
  end

  assign out_valid_o           = res_valid_q;
  assign out_data_o.out_letter = res_q[res_idx_q];
  assign out_data_o.last       = res_eom_q && (res_idx_q == last_idx);

endmodule

>>> src/pdc_checker.sv
// Port-level checks for the Playfair digram cipher and their binding to the top level.
module pdc_checker import pdc_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input pdc_out_t out_data_o
);

  // A stalled result transaction keeps its letter and flag.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // No result is offered while reset is held.
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result offered during reset");

  // The input only stalls while results are waiting to be taken.
  a_stall_cause: assert property (@(posedge clk_i)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

endmodule

bind playfair_digram_cipher pdc_checker u_pdc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
